// ===== rtl/lrb_pkg.sv =====
`timescale 1ns / 1ps

package lrb_pkg;

  localparam int unsigned TIME_W   = 32;
  localparam int unsigned JITTER_W = 16;
  localparam int unsigned OP_W     = 2;
  localparam int unsigned STATE_W  = 3;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned JITTER_SHIFT = 12;

  localparam logic [JITTER_SHIFT-1:0] JITTER_MASK = 12'hFFF;

  typedef enum logic [STATE_W-1:0] {
    ST_INACTIVE     = 3'd0,
    ST_DISCONNECTED = 3'd1,
    ST_CONNECTING   = 3'd2,
    ST_CONNECTED    = 3'd3,
    ST_BACKOFF      = 3'd4
  } lrb_state_t;

  typedef enum logic [OP_W-1:0] {
    OP_TICK    = 2'd0,
    OP_ENABLE  = 2'd1,
    OP_DISABLE = 2'd2
  } lrb_op_t;

  localparam logic [CFG_IDX_W-1:0] REG_BACKOFF_INITIAL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BACKOFF_MAX     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_JITTER_SPAN     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CONNECT_TIMEOUT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RETRY_ENABLE    = 3'd4;

  localparam logic [TIME_W-1:0]   RST_BACKOFF_INITIAL = 32'd1000;
  localparam logic [TIME_W-1:0]   RST_BACKOFF_MAX     = 32'd30000;
  localparam logic [JITTER_W-1:0] RST_JITTER_SPAN     = 16'd0;
  localparam logic [TIME_W-1:0]   RST_CONNECT_TIMEOUT = 32'd5000;
  localparam logic                RST_RETRY_ENABLE    = 1'b1;

endpackage

// ===== rtl/lrb_if.sv =====
`timescale 1ns / 1ps

interface lrb_cmd_if import lrb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [TIME_W-1:0] now_ms;
  logic              link_up;

  modport source (output valid, output op, output now_ms, output link_up, input ready);
  modport sink   (input valid, input op, input now_ms, input link_up, output ready);
endinterface

interface lrb_res_if import lrb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [STATE_W-1:0] link_state;
  logic               is_connected;
  logic               issue_stop;
  logic               issue_connect;
  logic               connected_event;
  logic               disconnected_event;

  modport source (output valid, output link_state, output is_connected, output issue_stop,
                  output issue_connect, output connected_event, output disconnected_event,
                  input ready);
  modport sink   (input valid, input link_state, input is_connected, input issue_stop,
                  input issue_connect, input connected_event, input disconnected_event,
                  output ready);
endinterface

interface lrb_cfg_if import lrb_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [TIME_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/link_reconnect_backoff_fsm.sv =====
`timescale 1ns / 1ps

// Connection supervisor with exponential backoff and jitter. Commands (tick, enable,
// disable) enter through an input register, are resolved against the supervisor state in
// combinational logic and leave through a result register, one result per command. A new
// command is taken every cycle while the result side keeps up; throughput is one command
// per clock through the input register and then the result register. Configuration
// writes are always accepted and take effect on the next command; indexes beyond the
// register list are ignored.
module link_reconnect_backoff_fsm
  import lrb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  lrb_cmd_if.sink    cmd,
  lrb_res_if.source  res,
  lrb_cfg_if.sink    cfg
);

  // configuration
  logic [TIME_W-1:0]   backoff_initial;
  logic [TIME_W-1:0]   backoff_max;
  logic [JITTER_W-1:0] jitter_span;
  logic [TIME_W-1:0]   connect_timeout;
  logic                retry_enable;

  // supervisor state
  lrb_state_t        fsm_state, fsm_state_next;
  logic              enabled, enabled_next;
  logic [TIME_W-1:0] last_attempt_time, last_attempt_time_next;
  logic [TIME_W-1:0] attempt_start_time, attempt_start_time_next;
  logic [TIME_W-1:0] backoff_interval, backoff_interval_next;

  // input stage
  logic              s1_valid;
  logic [OP_W-1:0]   s1_op;
  logic [TIME_W-1:0] s1_now;
  logic              s1_up;

  logic advance;
  logic stop, conn, ev_up, ev_down;

  assign cfg.ready = 1'b1;
  assign advance   = s1_valid && (!res.valid || res.ready);
  assign cmd.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      backoff_initial <= RST_BACKOFF_INITIAL;
      backoff_max     <= RST_BACKOFF_MAX;
      jitter_span     <= RST_JITTER_SPAN;
      connect_timeout <= RST_CONNECT_TIMEOUT;
      retry_enable    <= RST_RETRY_ENABLE;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_BACKOFF_INITIAL: backoff_initial <= cfg.data;
        REG_BACKOFF_MAX:     backoff_max     <= cfg.data;
        REG_JITTER_SPAN:     jitter_span     <= cfg.data[JITTER_W-1:0];
        REG_CONNECT_TIMEOUT: connect_timeout <= cfg.data;
        REG_RETRY_ENABLE:    retry_enable    <= cfg.data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd.ready) begin
      s1_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      s1_op  <= cmd.op;
      s1_now <= cmd.now_ms;
      s1_up  <= cmd.link_up;
    end
  end

  // backoff entry value: doubled, clamped, then jittered from the low time bits
  logic [TIME_W-1:0]                doubled, clamped, jittered, backoff_entry;
  logic [JITTER_SHIFT+JITTER_W-1:0] jitter_prod;
  logic [TIME_W-1:0]                since_attempt, since_start;

  always_comb begin
    doubled     = {backoff_interval[TIME_W-2:0], 1'b0};
    clamped     = (doubled > backoff_max) ? backoff_max : doubled;
    jitter_prod = (JITTER_SHIFT+JITTER_W)'(s1_now[JITTER_SHIFT-1:0] & JITTER_MASK)
                  * (JITTER_SHIFT+JITTER_W)'(jitter_span);
    jittered    = clamped
                  - TIME_W'(jitter_span[JITTER_W-1:1])
                  + TIME_W'(jitter_prod[JITTER_SHIFT+JITTER_W-1:JITTER_SHIFT]);
    backoff_entry = (jitter_span != '0) ? jittered : clamped;
    since_attempt = s1_now - last_attempt_time;
    since_start   = s1_now - attempt_start_time;
  end

  always_comb begin
    fsm_state_next          = fsm_state;
    enabled_next            = enabled;
    last_attempt_time_next  = last_attempt_time;
    attempt_start_time_next = attempt_start_time;
    backoff_interval_next   = backoff_interval;
    stop    = 1'b0;
    conn    = 1'b0;
    ev_up   = 1'b0;
    ev_down = 1'b0;
    case (s1_op)
      OP_ENABLE: begin
        enabled_next = 1'b1;
        if (fsm_state == ST_INACTIVE) fsm_state_next = ST_DISCONNECTED;
      end
      OP_DISABLE: begin
        if (enabled) begin
          if (fsm_state == ST_CONNECTED) begin
            ev_down = 1'b1;
            stop    = 1'b1;
          end
          fsm_state_next = ST_INACTIVE;
        end
        enabled_next = 1'b0;
      end
      OP_TICK: begin
        if (enabled) begin
          case (fsm_state)
            ST_DISCONNECTED: begin
              if (since_attempt >= backoff_interval) begin
                last_attempt_time_next  = s1_now;
                attempt_start_time_next = s1_now;
                fsm_state_next          = ST_CONNECTING;
                stop = 1'b1;
                conn = 1'b1;
              end
            end
            ST_CONNECTING: begin
              if (s1_up) begin
                fsm_state_next        = ST_CONNECTED;
                backoff_interval_next = backoff_initial;
                ev_up = 1'b1;
              end else if (since_start > connect_timeout) begin
                stop                   = 1'b1;
                backoff_interval_next  = backoff_entry;
                last_attempt_time_next = s1_now;
                fsm_state_next         = ST_BACKOFF;
              end
            end
            ST_CONNECTED: begin
              if (!s1_up) begin
                ev_down                = 1'b1;
                stop                   = 1'b1;
                backoff_interval_next  = backoff_entry;
                last_attempt_time_next = s1_now;
                fsm_state_next         = ST_BACKOFF;
              end
            end
            ST_BACKOFF: begin
              if (since_attempt >= backoff_interval && retry_enable)
                fsm_state_next = ST_DISCONNECTED;
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fsm_state          <= ST_INACTIVE;
      enabled            <= 1'b0;
      last_attempt_time  <= '0;
      attempt_start_time <= '0;
      backoff_interval   <= RST_BACKOFF_INITIAL;
    end else if (advance) begin
      fsm_state          <= fsm_state_next;
      enabled            <= enabled_next;
      last_attempt_time  <= last_attempt_time_next;
      attempt_start_time <= attempt_start_time_next;
      backoff_interval   <= backoff_interval_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (advance) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res.link_state         <= fsm_state_next;
      res.is_connected       <= enabled_next && (fsm_state_next == ST_CONNECTED);
      res.issue_stop         <= stop;
      res.issue_connect      <= conn;
      res.connected_event    <= ev_up;
      res.disconnected_event <= ev_down;
    end
  end

endmodule
